[sv/least_loaded_ring_selector_macros.svh]
// ----------------------------------------------------------------------------
// Least-loaded ring selector: assertion macros
// Shared property wrappers for the selector's checker.
// ----------------------------------------------------------------------------
`ifndef LEAST_LOADED_RING_SELECTOR_MACROS_SVH
`define LEAST_LOADED_RING_SELECTOR_MACROS_SVH

// Check outside reset only.
`define LLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check at every edge, reset included.
`define LLS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/lls_pkg.sv]
// ----------------------------------------------------------------------------
// Least-loaded ring selector: package
// Widths, ring orders, command and status codes shared by the block.
// ----------------------------------------------------------------------------
package lls_pkg;

  localparam int RING_COUNT = 4;
  localparam int MAX_NODES  = 8;
  localparam int RING_W     = 2;
  localparam int RANK_W     = 3;
  localparam int NODE_CNT_W = 4;
  localparam int IDX_W      = $clog2(MAX_NODES);
  localparam int COUNT_W    = 29;
  localparam int LOAD_W     = 31;
  localparam int WEIGHT_W   = 33;
  localparam int WIDE_W     = 4;

  localparam logic [WEIGHT_W-1:0] LOAD_LIMIT = WEIGHT_W'(1) << 30;

  typedef logic [RANK_W-1:0]   rank_t;
  typedef logic [RING_W-1:0]   ring_t;
  typedef logic [LOAD_W-1:0]   load_t;
  typedef logic [COUNT_W-1:0]  count_t;

  localparam rank_t RING_ORDER [RING_COUNT][MAX_NODES] = '{
    '{3'd0, 3'd3, 3'd2, 3'd1, 3'd5, 3'd6, 3'd7, 3'd4},
    '{3'd0, 3'd4, 3'd7, 3'd6, 3'd5, 3'd1, 3'd2, 3'd3},
    '{3'd0, 3'd2, 3'd6, 3'd4, 3'd5, 3'd7, 3'd3, 3'd1},
    '{3'd0, 3'd1, 3'd3, 3'd7, 3'd5, 3'd4, 3'd6, 3'd2}
  };

  typedef enum logic [0:0] {
    CMD_PICK    = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_RING   = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_LOCAL_RANK   = 2'd0,
    CFG_NODE_COUNT   = 2'd1,
    CFG_RING_IS_WIDE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    rank_t prev;
    rank_t next;
  } neigh_t;

  typedef struct packed {
    logic  found;
    ring_t ring;
  } pick_t;

endpackage

[sv/lls_neigh.sv]
// ----------------------------------------------------------------------------
// Least-loaded ring selector: neighbour lookup
// Finds the local node's previous and next rank in every ring order.
// ----------------------------------------------------------------------------
module lls_neigh
  import lls_pkg::*;
(
  input  rank_t                 local_rank,
  input  logic [NODE_CNT_W-1:0] node_count,
  output neigh_t                neigh [RING_COUNT]
);

  always_comb begin
    logic [NODE_CNT_W-1:0] n;
    logic [IDX_W-1:0]      last;
    logic [IDX_W-1:0]      pi;
    logic [IDX_W-1:0]      ni;
    n    = (node_count > NODE_CNT_W'(MAX_NODES)) ? NODE_CNT_W'(MAX_NODES) : node_count;
    last = IDX_W'(n - NODE_CNT_W'(1));
    for (int r = 0; r < RING_COUNT; r++) begin
      neigh[r] = '0;
      // later matches overwrite earlier ones
      for (int j = 0; j < MAX_NODES; j++) begin
        pi = (j == 0) ? last : IDX_W'(j - 1);
        ni = (NODE_CNT_W'(j + 1) == n) ? '0 : IDX_W'(j + 1);
        if ((NODE_CNT_W'(j) < n) && (RING_ORDER[r][j] == local_rank)) begin
          neigh[r].prev = RING_ORDER[r][pi];
          neigh[r].next = RING_ORDER[r][ni];
        end
      end
    end
  end

endmodule

[sv/lls_pick.sv]
// ----------------------------------------------------------------------------
// Least-loaded ring selector: weighted pick
// Weighs each ring's load plus the request and picks the lightest one.
// ----------------------------------------------------------------------------
module lls_pick
  import lls_pkg::*;
(
  input  load_t              ring_load [RING_COUNT],
  input  count_t             count,
  input  logic [WIDE_W-1:0]  ring_is_wide,
  output pick_t              pick
);

  always_comb begin
    logic [WEIGHT_W-1:0] best;
    logic [WEIGHT_W-1:0] after;
    best = LOAD_LIMIT;
    pick = '0;
    for (int r = 0; r < RING_COUNT; r++) begin
      after = WEIGHT_W'(ring_load[r]) + WEIGHT_W'(count);
      // narrow rings count double
      if ((r >= WIDE_W) || !ring_is_wide[r % WIDE_W]) begin
        after = after << 1;
      end
      // strict compare keeps the lowest ring on a tie
      if (after < best) begin
        best       = after;
        pick.found = 1'b1;
        pick.ring  = RING_W'(r);
      end
    end
  end

endmodule

[sv/least_loaded_ring_selector.sv]
// ----------------------------------------------------------------------------
// Least-loaded ring selector
// Tracks outstanding load on four rings; picks or releases load per request.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: tuser is the command (pick or release),
// tdata carries the element count and, for a release, the ring number.
// Each transaction yields exactly one m_ transaction: the chosen ring with
// the local node's neighbours in tdata and a status code in tuser.
// A request sits in the input register, where the weighted compare of all
// four rings and the load update run; the result register follows.
// One request is taken every cycle while the receiver does not stall,
// bounded by the single load-update path per cycle.
// When the receiver stalls, the result holds in the output register and the
// input register still takes one more request; further requests wait.
// Synchronous reset clears all loads, both stage valids and sets local_rank
// to 0, node_count to 8 and ring_is_wide to 3. The cfg_ port writes one
// register per cycle with cfg_we; write it only while the block is idle.
// ----------------------------------------------------------------------------
module least_loaded_ring_selector
  import lls_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [28:0] element_count, [30:29] release_ring
  input  logic [0:0]  s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [1:0] chosen_ring, [4:2] previous_node, [7:5] next_node
  output logic [1:0]  m_tuser,   // [1:0] status
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  rank_t                 local_rank;
  logic [NODE_CNT_W-1:0] node_count;
  logic [WIDE_W-1:0]     ring_is_wide;

  load_t   ring_load      [RING_COUNT];
  load_t   ring_load_next [RING_COUNT];

  logic    in_valid;
  cmd_t    in_cmd;
  count_t  in_count;
  ring_t   in_rel;

  logic    advance;
  pick_t   pick;
  neigh_t  neigh [RING_COUNT];

  ring_t   chosen;
  rank_t   prev_node;
  rank_t   next_node;
  status_t status;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  lls_pick u_pick (
    .ring_load    (ring_load),
    .count        (in_count),
    .ring_is_wide (ring_is_wide),
    .pick         (pick)
  );

  lls_neigh u_neigh (
    .local_rank (local_rank),
    .node_count (node_count),
    .neigh      (neigh)
  );

  always_comb begin
    ring_load_next = ring_load;
    chosen         = '0;
    prev_node      = '0;
    next_node      = '0;
    status         = ST_OK;
    if (in_cmd == CMD_PICK) begin
      if (pick.found) begin
        ring_load_next[pick.ring] = ring_load[pick.ring] + LOAD_W'(in_count);
        chosen    = pick.ring;
        prev_node = neigh[pick.ring].prev;
        next_node = neigh[pick.ring].next;
      end else begin
        status = ST_NO_RING;
      end
    end else begin
      chosen    = in_rel;
      prev_node = neigh[in_rel].prev;
      next_node = neigh[in_rel].next;
      // clamp at zero on underflow
      if (LOAD_W'(in_count) > ring_load[in_rel]) begin
        ring_load_next[in_rel] = '0;
        status                 = ST_UNDERFLOW;
      end else begin
        ring_load_next[in_rel] = ring_load[in_rel] - LOAD_W'(in_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      local_rank   <= '0;
      node_count   <= NODE_CNT_W'(MAX_NODES);
      ring_is_wide <= WIDE_W'(3);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOCAL_RANK:   local_rank   <= cfg_data[RANK_W-1:0];
        CFG_NODE_COUNT:   node_count   <= cfg_data[NODE_CNT_W-1:0];
        CFG_RING_IS_WIDE: ring_is_wide <= cfg_data[WIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < RING_COUNT; r++) begin
        ring_load[r] <= '0;
      end
    end else if (advance) begin
      ring_load <= ring_load_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd   <= cmd_t'(s_tuser[0]);
      in_count <= s_tdata[COUNT_W-1:0];
      in_rel   <= s_tdata[COUNT_W +: RING_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // hold the result while the receiver stalls
  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {next_node, prev_node, chosen};
      m_tuser <= status;
    end
  end

endmodule

[sv/lls_checker.sv]
// ----------------------------------------------------------------------------
// Least-loaded ring selector: port checker
// Watches the selector's ports and flags result streams that cannot occur.
// ----------------------------------------------------------------------------
`include "least_loaded_ring_selector_macros.svh"

module lls_checker
  import lls_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic [1:0]  m_tuser
);

  logic       stalled;
  logic       no_ring;
  logic       status_known;
  logic [9:0] m_word;

  assign stalled      = m_tvalid && !m_tready;
  assign no_ring      = m_tvalid && (m_tuser == ST_NO_RING);
  assign status_known = (m_tuser == ST_OK) || (m_tuser == ST_NO_RING) ||
                        (m_tuser == ST_UNDERFLOW);
  assign m_word       = {m_tuser, m_tdata};

  `LLS_ASSERT(a_stall_hold, stalled |=> m_tvalid && $stable(m_word), "result changed while stalled")

  `LLS_ASSERT(a_status_code, m_tvalid |-> status_known, "undefined status code")

  `LLS_ASSERT(a_no_ring_zero, no_ring |-> (m_tdata == 8'd0), "rejected pick reports a ring")

  `LLS_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !m_tvalid, "result valid straight after reset")

endmodule

bind least_loaded_ring_selector lls_checker u_lls_checker (.*);
